// ===== hw/rtl/ulfm_pkg.sv =====
// ulfm_pkg: shared types and constants for the ultrasonic level frame monitor.
// Used by ulfm_tracker, ultrasonic_level_frame_monitor, ulfm_checker and the testbench; depends on nothing.

package ulfm_pkg;

   localparam int TIMER_BITS_DEF = 16;
   localparam int DIST_W         = 16;
   localparam int BYTE_W         = 8;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

   // configuration reset values
   localparam logic              RST_ENABLE  = 1'b1;
   localparam logic [DIST_W-1:0] RST_ZERO_MM = 16'd2500;
   localparam logic [DIST_W-1:0] RST_MIN_MM  = 16'd280;
   localparam logic [DIST_W-1:0] RST_MAX_MM  = 16'd2500;
   localparam logic [DIST_W-1:0] RST_TIMEOUT = 16'd3000;
   localparam logic [DIST_W-1:0] RST_GRACE   = 16'd20000;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELD_W = 2 + 2 * DIST_W + 2;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef enum logic [2:0] {
      CSR_ENABLE  = 3'd0,
      CSR_ZERO    = 3'd1,
      CSR_MIN     = 3'd2,
      CSR_MAX     = 3'd3,
      CSR_TIMEOUT = 3'd4,
      CSR_GRACE   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_NONE   = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_BADSUM = 2'd2,
      ST_RANGE  = 2'd3
   } frame_status_type;

   typedef enum logic [1:0] {
      POS_HUNT = 2'd0,
      POS_HIGH = 2'd1,
      POS_LOW  = 2'd2,
      POS_SUM  = 2'd3
   } frame_pos_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef struct packed {
      logic              enable;
      logic [DIST_W-1:0] zero_mm;
      logic [DIST_W-1:0] min_mm;
      logic [DIST_W-1:0] max_mm;
      logic [DIST_W-1:0] timeout;
      logic [DIST_W-1:0] grace;
   } cfg_type;

   typedef struct packed {
      logic              reading_valid;
      logic              sensor_detected;
      logic [DIST_W-1:0] distance_mm;
      logic [DIST_W-1:0] water_level_mm;
      frame_status_type  frame_status;
   } result_type;

endpackage

// ===== hw/rtl/ultrasonic_level_frame_monitor.sv =====
// ultrasonic_level_frame_monitor: top level with CSR bank, tracker and result register.
// Depends on ulfm_pkg and ulfm_tracker.
//
//  channel  direction  width  transaction
//  req_     in         1+8    one UART byte or one millisecond tick
//  rsp_     out        40     one result per req transaction
//  csr_     in/out     32     register write/read, pready always high
//
// A new req is taken every cycle while rsp drains.
// The single result register sets the rate: req_tready = !rsp_tvalid || rsp_tready.
// Synchronous active-high reset loads register defaults and returns to sync hunt.
// A stalled rsp holds its data; req waits only while that register is full.

module ultrasonic_level_frame_monitor
   import ulfm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // req
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  logic                   req_tuser,   // [0] opcode
   // rsp
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] reading_valid, [1] sensor_detected, [17:2] distance_mm,
   // [33:18] water_level_mm, [35:34] frame_status, [39:36] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // csr
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type                cfg_ff, cfg_in;
   csr_index_type          csr_index;
   logic                   csr_write;
   logic                   take;
   result_type             result;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ENABLE:  cfg_in.enable  = csr_pwdata[0];
            CSR_ZERO:    cfg_in.zero_mm = csr_pwdata[DIST_W-1:0];
            CSR_MIN:     cfg_in.min_mm  = csr_pwdata[DIST_W-1:0];
            CSR_MAX:     cfg_in.max_mm  = csr_pwdata[DIST_W-1:0];
            CSR_TIMEOUT: cfg_in.timeout = csr_pwdata[DIST_W-1:0];
            CSR_GRACE:   cfg_in.grace   = csr_pwdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_ENABLE:  csr_prdata = CSR_DATA_W'(cfg_ff.enable);
         CSR_ZERO:    csr_prdata = CSR_DATA_W'(cfg_ff.zero_mm);
         CSR_MIN:     csr_prdata = CSR_DATA_W'(cfg_ff.min_mm);
         CSR_MAX:     csr_prdata = CSR_DATA_W'(cfg_ff.max_mm);
         CSR_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.timeout);
         CSR_GRACE:   csr_prdata = CSR_DATA_W'(cfg_ff.grace);
         default:     csr_prdata = '0;
      endcase
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   ulfm_tracker #(
      .TIMER_BITS (TIMER_BITS)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .opcode  (opcode_type'(req_tuser)),
      .rx_byte (req_tdata[BYTE_W-1:0]),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, result.frame_status, result.water_level_mm,
                         result.distance_mm, result.sensor_detected, result.reading_valid};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable  <= RST_ENABLE;
         cfg_ff.zero_mm <= RST_ZERO_MM;
         cfg_ff.min_mm  <= RST_MIN_MM;
         cfg_ff.max_mm  <= RST_MAX_MM;
         cfg_ff.timeout <= RST_TIMEOUT;
         cfg_ff.grace   <= RST_GRACE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (take && !cfg_ff.enable) |=> (rsp_data_ff == '0))
      else $error("disabled result not zero");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("transaction taken but no result held");

   a_status_only_bytes: assert property (@(posedge clock) disable iff (reset)
      (take && req_tuser) |=> (rsp_data_ff[RSP_FIELD_W-1 -: 2] == ST_NONE))
      else $error("frame status set on a tick");

endmodule

// ===== hw/rtl/ulfm_tracker.sv =====
// ulfm_tracker: frame parser, held reading and tick aging timers.
// Depends on ulfm_pkg; the result comes out combinationally for the transaction taken.

module ulfm_tracker
   import ulfm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  opcode_type        opcode,
   input  logic [BYTE_W-1:0] rx_byte,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam int CMP_W = (TIMER_BITS > DIST_W) ? TIMER_BITS : DIST_W;

   frame_pos_type         pos_ff, pos_in;
   logic [BYTE_W-1:0]     high_ff, high_in;
   logic [BYTE_W-1:0]     low_ff, low_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [DIST_W-1:0]     level_ff, level_in;
   logic                  valid_ff, valid_in;
   logic                  detected_ff, detected_in;
   logic                  ever_ff, ever_in;
   logic [TIMER_BITS-1:0] tsg_ff, tsg_in;
   logic [TIMER_BITS-1:0] tss_ff, tss_in;
   frame_status_type      status;

   logic [BYTE_W-1:0]     sum;
   logic [DIST_W-1:0]     frame_dist;
   logic [TIMER_BITS-1:0] tsg_inc, tss_inc;
   logic                  recent;

   assign sum        = SYNC_BYTE + high_ff + low_ff;
   assign frame_dist = {high_ff, low_ff};
   assign tsg_inc    = (tsg_ff == '1) ? tsg_ff : tsg_ff + 1'b1;
   assign tss_inc    = (tss_ff == '1) ? tss_ff : tss_ff + 1'b1;
   assign recent     = ever_ff && (CMP_W'(tsg_inc) < CMP_W'(cfg.timeout));

   // frame position
   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         if (!cfg.enable) begin
            pos_in = POS_HUNT;
         end else if (opcode == OP_BYTE) begin
            unique case (pos_ff)
               POS_HUNT: if (rx_byte == SYNC_BYTE) pos_in = POS_HIGH;
               POS_HIGH: pos_in = POS_LOW;
               POS_LOW:  pos_in = POS_SUM;
               POS_SUM:  pos_in = POS_HUNT;
            endcase
         end
      end
   end

   // reading, flags and timers
   always_comb begin
      high_in     = high_ff;
      low_in      = low_ff;
      dist_in     = dist_ff;
      level_in    = level_ff;
      valid_in    = valid_ff;
      detected_in = detected_ff;
      ever_in     = ever_ff;
      tsg_in      = tsg_ff;
      tss_in      = tss_ff;
      status      = ST_NONE;
      if (take) begin
         if (opcode == OP_TICK) begin
            tsg_in = tsg_inc;
            tss_in = tss_inc;
         end
         if (!cfg.enable) begin
            dist_in     = '0;
            level_in    = '0;
            valid_in    = 1'b0;
            detected_in = 1'b0;
         end else if (opcode == OP_TICK) begin
            if (!recent) begin
               dist_in  = '0;
               level_in = '0;
               valid_in = 1'b0;
               if (CMP_W'(tss_inc) >= CMP_W'(cfg.grace)) detected_in = 1'b0;
            end
         end else begin
            unique case (pos_ff)
               POS_HUNT: ;
               POS_HIGH: high_in = rx_byte;
               POS_LOW:  low_in  = rx_byte;
               POS_SUM: begin
                  priority if (sum != rx_byte) begin
                     status = ST_BADSUM;
                  end else if (frame_dist < cfg.min_mm || frame_dist > cfg.max_mm) begin
                     status = ST_RANGE;
                  end else begin
                     status      = ST_ACCEPT;
                     dist_in     = frame_dist;
                     level_in    = (cfg.zero_mm > frame_dist) ? cfg.zero_mm - frame_dist : '0;
                     valid_in    = 1'b1;
                     detected_in = 1'b1;
                     ever_in     = 1'b1;
                     tsg_in      = '0;
                  end
               end
            endcase
         end
      end
   end

   // result of the transaction being taken; all zero when disabled
   always_comb begin
      result.reading_valid   = valid_in;
      result.sensor_detected = detected_in;
      result.distance_mm     = dist_in;
      result.water_level_mm  = level_in;
      result.frame_status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_HUNT;
         high_ff     <= '0;
         low_ff      <= '0;
         dist_ff     <= '0;
         level_ff    <= '0;
         valid_ff    <= 1'b0;
         detected_ff <= 1'b0;
         ever_ff     <= 1'b0;
         tsg_ff      <= '0;
         tss_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         high_ff     <= high_in;
         low_ff      <= low_in;
         dist_ff     <= dist_in;
         level_ff    <= level_in;
         valid_ff    <= valid_in;
         detected_ff <= detected_in;
         ever_ff     <= ever_in;
         tsg_ff      <= tsg_in;
         tss_ff      <= tss_in;
      end
   end

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> (dist_ff == '0 && level_ff == '0))
      else $error("held reading not cleared while invalid");

   a_valid_detected: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (detected_ff && ever_ff))
      else $error("valid reading without detection");

   a_accept_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (take && status == ST_ACCEPT) |=> (valid_ff && tsg_ff == '0))
      else $error("accepted frame did not load the reading");

endmodule

// ===== tb/ulfm_checker.sv =====
// ulfm_checker: watches the req, rsp and csr channels of the level frame monitor,
// predicts every result from its own copy of state and registers, and counts mismatches.
// Depends on ulfm_pkg only.

module ulfm_checker
   import ulfm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  logic                   req_tuser,   // [0] opcode
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] reading_valid, [1] sensor_detected, [17:2] distance_mm,
   // [33:18] water_level_mm, [35:34] frame_status, [39:36] zero
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [CSR_DATA_W-1:0]  csr_prdata,
   input  logic                   csr_pready,
   output int                     mismatches,
   output int                     pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TW = TIMER_BITS_DEF;

   cfg_type           regs;
   frame_pos_type     pos;
   logic [BYTE_W-1:0] hi_byte;
   logic [BYTE_W-1:0] lo_byte;
   logic [DIST_W-1:0] held_dist;
   logic [DIST_W-1:0] held_level;
   logic              valid_q;
   logic              detected_q;
   logic              ever_good;
   logic [TW-1:0]     since_good;
   logic [TW-1:0]     since_start;

   result_type expected_results[$];

   initial begin
      mismatches      = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   task automatic clear_monitor();
      regs.enable  = RST_ENABLE;
      regs.zero_mm = RST_ZERO_MM;
      regs.min_mm  = RST_MIN_MM;
      regs.max_mm  = RST_MAX_MM;
      regs.timeout = RST_TIMEOUT;
      regs.grace   = RST_GRACE;
      pos          = POS_HUNT;
      hi_byte      = '0;
      lo_byte      = '0;
      held_dist    = '0;
      held_level   = '0;
      valid_q      = 1'b0;
      detected_q   = 1'b0;
      ever_good    = 1'b0;
      since_good   = '0;
      since_start  = '0;
      expected_results.delete();
   endtask

   function automatic logic [CSR_DATA_W-1:0] reg_value(input csr_index_type idx);
      case (idx)
         CSR_ENABLE:  return CSR_DATA_W'(regs.enable);
         CSR_ZERO:    return CSR_DATA_W'(regs.zero_mm);
         CSR_MIN:     return CSR_DATA_W'(regs.min_mm);
         CSR_MAX:     return CSR_DATA_W'(regs.max_mm);
         CSR_TIMEOUT: return CSR_DATA_W'(regs.timeout);
         CSR_GRACE:   return CSR_DATA_W'(regs.grace);
         default:     return '0;
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      case (idx)
         CSR_ENABLE:  regs.enable  = v[0];
         CSR_ZERO:    regs.zero_mm = v[DIST_W-1:0];
         CSR_MIN:     regs.min_mm  = v[DIST_W-1:0];
         CSR_MAX:     regs.max_mm  = v[DIST_W-1:0];
         CSR_TIMEOUT: regs.timeout = v[DIST_W-1:0];
         CSR_GRACE:   regs.grace   = v[DIST_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drop_reading();
      held_dist  = '0;
      held_level = '0;
      valid_q    = 1'b0;
   endtask

   // one byte or tick in, one result out
   task automatic track_level(input opcode_type op, input logic [BYTE_W-1:0] b,
                              output result_type r);
      frame_status_type  st;
      logic [BYTE_W-1:0] sum;
      logic [DIST_W-1:0] d;
      st = ST_NONE;
      if (!regs.enable) begin
         if (op == OP_TICK) begin
            since_start = sat_inc(since_start);
            since_good  = sat_inc(since_good);
         end
         drop_reading();
         detected_q = 1'b0;
         pos        = POS_HUNT;
      end else if (op == OP_TICK) begin
         since_start = sat_inc(since_start);
         since_good  = sat_inc(since_good);
         if (!(ever_good && since_good < regs.timeout)) begin
            drop_reading();
            if (since_start >= regs.grace)
               detected_q = 1'b0;
         end
      end else begin
         case (pos)
            POS_HUNT: if (b == SYNC_BYTE) pos = POS_HIGH;
            POS_HIGH: begin
               hi_byte = b;
               pos     = POS_LOW;
            end
            POS_LOW: begin
               lo_byte = b;
               pos     = POS_SUM;
            end
            default: begin
               sum = SYNC_BYTE + hi_byte + lo_byte;
               d   = {hi_byte, lo_byte};
               pos = POS_HUNT;
               if (sum != b) begin
                  st = ST_BADSUM;
               end else if (d < regs.min_mm || d > regs.max_mm) begin
                  st = ST_RANGE;
               end else begin
                  held_dist  = d;
                  held_level = (regs.zero_mm > d) ? regs.zero_mm - d : '0;
                  valid_q    = 1'b1;
                  detected_q = 1'b1;
                  ever_good  = 1'b1;
                  since_good = '0;
                  st         = ST_ACCEPT;
               end
            end
         endcase
      end
      r.reading_valid   = valid_q;
      r.sensor_detected = detected_q;
      r.distance_mm     = held_dist;
      r.water_level_mm  = held_level;
      r.frame_status    = st;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         clear_monitor();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite)
               write_reg(csr_index_type'(csr_paddr[4:2]), csr_pwdata);
            else if (csr_prdata !== reg_value(csr_index_type'(csr_paddr[4:2])))
               report_mismatch($sformatf("csr read at 0x%0h", csr_paddr), csr_prdata,
                               reg_value(csr_index_type'(csr_paddr[4:2])));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata[31:0], 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.reading_valid)
                  report_mismatch("reading_valid", rsp_tdata[0], want.reading_valid);
               if (rsp_tdata[1] !== want.sensor_detected)
                  report_mismatch("sensor_detected", rsp_tdata[1], want.sensor_detected);
               if (rsp_tdata[17:2] !== want.distance_mm)
                  report_mismatch("distance_mm", rsp_tdata[17:2], want.distance_mm);
               if (rsp_tdata[33:18] !== want.water_level_mm)
                  report_mismatch("water_level_mm", rsp_tdata[33:18], want.water_level_mm);
               if (rsp_tdata[35:34] !== want.frame_status)
                  report_mismatch("frame_status", rsp_tdata[35:34], want.frame_status);
               if (rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W] !== '0)
                  report_mismatch("tdata padding", rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W], 0);
            end
         end
         if (req_tvalid && req_tready) begin
            track_level(opcode_type'(req_tuser), req_tdata, want);
            expected_results.push_back(want);
         end
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== tb/tb_ultrasonic_level_frame_monitor.sv =====
// tb_ultrasonic_level_frame_monitor: stimulus, register setup and verdict for the
// level frame monitor. Depends on ulfm_pkg, ulfm_checker and the block itself.

module tb_ultrasonic_level_frame_monitor
   import ulfm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;   // [7:0] rx_byte
   logic                   req_tuser   = 1'b0; // [0] opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // [0] reading_valid, [1] sensor_detected, [17:2] distance_mm,
   // [33:18] water_level_mm, [35:34] frame_status, [39:36] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   int mismatches;
   int pending_results;
   int items_sent    = 0;
   int quiet_cycles  = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   bit calm          = 1'b0;
   int cur_min       = RST_MIN_MM;
   int cur_max       = RST_MAX_MM;
   int cur_timeout   = RST_TIMEOUT;

   always #1 clock = ~clock;

   ultrasonic_level_frame_monitor u_top (.*);

   ulfm_checker u_checker (.*);

   // nothing moving on any channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result sink: random stalls, plus a long hold-off on request
   initial begin : sink
      int stall_left;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // valid stays high between back-to-back transactions
   task automatic send_item(input opcode_type op, input logic [BYTE_W-1:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= op;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic send_frame(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
                             input logic [BYTE_W-1:0] sum);
      send_item(OP_BYTE, SYNC_BYTE);
      send_item(OP_BYTE, hi);
      send_item(OP_BYTE, lo);
      send_item(OP_BYTE, sum);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [CSR_DATA_W-1:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input bit en, input int zero_mm, input int min_mm,
                                 input int max_mm, input int timeout, input int grace);
      wait_drained();
      csr_access(1'b1, CSR_ENABLE, CSR_DATA_W'(en));
      csr_access(1'b1, CSR_ZERO, CSR_DATA_W'(zero_mm));
      csr_access(1'b1, CSR_MIN, CSR_DATA_W'(min_mm));
      csr_access(1'b1, CSR_MAX, CSR_DATA_W'(max_mm));
      csr_access(1'b1, CSR_TIMEOUT, CSR_DATA_W'(timeout));
      csr_access(1'b1, CSR_GRACE, CSR_DATA_W'(grace));
      for (int i = 0; i <= CSR_GRACE; i++)
         csr_access(1'b0, csr_index_type'(i), '0);
      cur_min     = min_mm;
      cur_max     = max_mm;
      cur_timeout = timeout;
   endtask

   // one random piece of traffic: mostly well-formed frames, some broken ones,
   // tick bursts that can outlast a stale timeout below 64 ticks, and line noise
   task automatic random_unit();
      int                r;
      int                d;
      int                n;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] sum;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0)
         calm = ~calm;
      if (r < 73) begin
         if (r < 55 && cur_min <= cur_max) begin
            case ($urandom_range(0, 5))
               0:       d = cur_min;
               1:       d = cur_max;
               default: d = $urandom_range(cur_min, cur_max);
            endcase
         end else if (r < 55) begin
            d = $urandom_range(0, 65535);
         end else if (r < 65 && cur_min > 0 && ($urandom_range(0, 1) || cur_max == 65535)) begin
            d = (cur_min > 1 && $urandom_range(0, 1)) ? $urandom_range(0, cur_min - 1)
                                                       : cur_min - 1;
         end else if (r < 65 && cur_max < 65535) begin
            d = $urandom_range(0, 1) ? cur_max + 1 : $urandom_range(cur_max + 1, 65535);
         end else begin
            d = $urandom_range(0, 65535);
         end
         hi  = d[15:8];
         lo  = d[7:0];
         sum = SYNC_BYTE + hi + lo;
         // checksum corruption
         if (r >= 65)
            sum = sum ^ BYTE_W'($urandom_range(1, 255));
         send_frame(hi, lo, sum);
      end else if (r < 88) begin
         n = $urandom_range(1, (cur_timeout < 64) ? cur_timeout + 3 : 6);
         repeat (n) send_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
      end else if (r < 95) begin
         n = $urandom_range(1, 4);
         repeat (n) send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
      end else begin
         // truncated frame, the next bytes get absorbed as its data
         send_item(OP_BYTE, SYNC_BYTE);
         n = $urandom_range(0, 2);
         repeat (n) send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_random(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target)
         random_unit();
   endtask

   initial begin : stimulus
      int mn;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      send_item(OP_TICK, 8'h00);             // tick before any good frame
      send_item(OP_BYTE, 8'h00);             // noise while hunting
      send_item(OP_BYTE, 8'h7F);
      send_frame(8'h03, 8'hE8, 8'hEA);       // 1000 mm accepted
      send_frame(8'h09, 8'hC4, 8'hCC);       // at zero distance, level 0
      send_frame(8'hFF, 8'hFF, 8'hFD);       // sync value as data, out of range
      send_frame(8'h01, 8'h18, 8'h18);       // exactly the minimum
      send_frame(8'h03, 8'hE8, 8'hEB);       // bad checksum
      send_item(OP_TICK, 8'hFF);

      run_random(150);

      apply_settings(1'b1, 3000, 280, 2500, 5, 30);
      run_random(100);
      hold_requests++;
      run_random(250);

      apply_settings(1'b1, 65535, 0, 65535, 1, 0);
      run_random(100);
      wait_drained();
      run_random(150);

      // zero timeout: every tick drops the reading
      apply_settings(1'b1, 2500, 280, 2500, 0, 10);
      run_random(100);

      apply_settings(1'b0, 2500, 280, 2500, 8, 40);
      run_random(150);

      mn = $urandom_range(0, 1000);
      apply_settings(1'b1, 0, mn, $urandom_range(1000, 5000), 65535, 65535);
      run_random(200);

      // empty accept window
      apply_settings(1'b1, 1200, 3000, 100, 4, 65535);
      run_random(100);

      repeat (3) begin
         mn = $urandom_range(0, 2000);
         apply_settings(1'b1, $urandom_range(0, 65535), mn, $urandom_range(mn, 65535),
                        $urandom_range(1, 40), $urandom_range(0, 300));
         run_random(200);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending_results == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
